// File: hdl/vsvm_pkg.sv
// Shared constants and types for the six-neighbour surface voxel marker.
// No dependencies; compiled first.
package vsvm_pkg;

  localparam int MAX_X_DEFAULT      = 256;
  localparam int MAX_Y_DEFAULT      = 256;
  localparam int VALUE_BITS_DEFAULT = 16;

  // most planes per volume; a larger size_z is clamped to this value
  localparam int MAX_Z = 1024;

  localparam int VOXEL_W     = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;

  localparam int SIZE_XY_W     = 9;
  localparam int SIZE_Z_W      = 11;
  localparam int SIZE_XY_LIMIT = 511;

  localparam logic [SIZE_XY_W-1:0] SIZE_XY_RESET = 9'd256;
  localparam logic [SIZE_Z_W-1:0]  SIZE_Z_RESET  = 11'd256;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } reg_index_t;

  // geometry setup sequence after reset or a size write
  typedef enum logic [2:0] {
    CFG_CLAMP    = 3'd0,
    CFG_AREA     = 3'd1,
    CFG_VOLUME   = 3'd2,
    CFG_POINTERS = 3'd3,
    CFG_READY    = 3'd4
  } cfg_state_t;

  // control that travels with a word down the pipeline
  typedef struct packed {
    logic emit;
    logic x_lo;
    logic x_hi;
    logic y_lo;
    logic y_hi;
    logic z_lo;
    logic z_hi;
    logic last;
  } vsvm_tag_t;

endpackage

// File: hdl/vsvm_if.sv
// Valid/ready channel interfaces: voxel input, result output, configuration writes.
// Depends on vsvm_pkg for payload widths.
interface vsvm_voxel_if
  import vsvm_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VOXEL_W-1:0] voxel_value;
  logic                      drain;

  modport source (output valid, output voxel_value, output drain, input ready);
  modport sink   (input valid, input voxel_value, input drain, output ready);
endinterface

interface vsvm_result_if
  import vsvm_pkg::*;
();
  logic valid;
  logic ready;
  logic surface_flag;
  logic last_voxel;

  modport source (output valid, output surface_flag, output last_voxel, input ready);
  modport sink   (input valid, input surface_flag, input last_voxel, output ready);
endinterface

interface vsvm_cfg_if
  import vsvm_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/vsvm_ram.sv
// Generic simple dual-port RAM: one write port, two registered read ports.
// Read of the address being written returns the old contents. No dependencies.
module vsvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: hdl/volume_surface_voxel_marker_unit.sv
// Six-neighbour surface voxel marker. Latency path: the word that releases a result (the
// voxel one plane above, or a drain word) passes stage 1, stage 2 and the result register.
// Throughput: one word per cycle while results are not stalled, set by the single write port
// of each ring memory. Reset: positions clear, sizes go to 256, then geometry setup (clamp,
// area, volume, pointers) with voxel ready low; a size write repeats that setup. The ring
// memories are never cleared. Depends on vsvm_pkg, vsvm_if and vsvm_ram.
module volume_surface_voxel_marker_unit
  import vsvm_pkg::*;
#(
  parameter int MAX_X      = MAX_X_DEFAULT,
  parameter int MAX_Y      = MAX_Y_DEFAULT,
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  vsvm_voxel_if.sink    voxels,
  vsvm_result_if.source results,
  vsvm_cfg_if.sink      cfg
);

  localparam int X_LIM  = (MAX_X < SIZE_XY_LIMIT) ? MAX_X : SIZE_XY_LIMIT;
  localparam int Y_LIM  = (MAX_Y < SIZE_XY_LIMIT) ? MAX_Y : SIZE_XY_LIMIT;
  localparam int X_W    = $clog2(X_LIM + 1);
  localparam int Y_W    = $clog2(Y_LIM + 1);
  localparam int Z_W    = $clog2(MAX_Z + 1);
  localparam int XY_W   = $clog2(X_LIM * Y_LIM + 1);
  localparam int POS_W  = $clog2(X_LIM * Y_LIM * MAX_Z + 1);
  localparam int DEPTH1 = 2 * X_LIM * Y_LIM + 1;
  localparam int DEPTH2 = 2 * X_LIM + 1;
  localparam int A1_W   = $clog2(DEPTH1);
  localparam int A2_W   = $clog2(DEPTH2);

  function automatic logic [A1_W-1:0] ring1_next(input logic [A1_W-1:0] p);
    return (p == A1_W'(DEPTH1 - 1)) ? '0 : p + A1_W'(1);
  endfunction

  function automatic logic [A2_W-1:0] ring2_next(input logic [A2_W-1:0] p);
    return (p == A2_W'(DEPTH2 - 1)) ? '0 : p + A2_W'(1);
  endfunction

  // ---------------- configuration and geometry ----------------
  logic [SIZE_XY_W-1:0] size_x;
  logic [SIZE_XY_W-1:0] size_y;
  logic [SIZE_Z_W-1:0]  size_z;
  logic                 cfg_write;

  cfg_state_t cfg_state, cfg_state_next;
  logic ld_clamp, ld_area, ld_volume, ld_pointers, geom_ready;

  logic [X_W-1:0]  sx, sx_clamped, sx_less1;
  logic [Y_W-1:0]  sy, sy_clamped;
  logic [Z_W-1:0]  sz, sz_clamped;
  logic [XY_W-1:0] sxy, d_psx;
  logic [POS_W-1:0] total;
  logic [X_W+Y_W-1:0]  area_product;
  logic [XY_W+Z_W-1:0] volume_product;
  logic byp_psx, byp_p1;

  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid && (cfg.index == REG_SIZE_X || cfg.index == REG_SIZE_Y ||
                                   cfg.index == REG_SIZE_Z);

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_XY_RESET;
      size_y <= SIZE_XY_RESET;
      size_z <= SIZE_Z_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SIZE_X: size_x <= cfg.data[SIZE_XY_W-1:0];
        REG_SIZE_Y: size_y <= cfg.data[SIZE_XY_W-1:0];
        REG_SIZE_Z: size_z <= cfg.data[SIZE_Z_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_state <= CFG_CLAMP;
    end else begin
      cfg_state <= cfg_state_next;
    end
  end

  always_comb begin
    cfg_state_next = cfg_state;
    case (cfg_state)
      CFG_CLAMP:    cfg_state_next = CFG_AREA;
      CFG_AREA:     cfg_state_next = CFG_VOLUME;
      CFG_VOLUME:   cfg_state_next = CFG_POINTERS;
      CFG_POINTERS: cfg_state_next = CFG_READY;
      CFG_READY:    cfg_state_next = CFG_READY;
      default:      cfg_state_next = CFG_CLAMP;
    endcase
    if (cfg_write) begin
      cfg_state_next = CFG_CLAMP;
    end
  end

  always_comb begin
    ld_clamp    = 1'b0;
    ld_area     = 1'b0;
    ld_volume   = 1'b0;
    ld_pointers = 1'b0;
    geom_ready  = 1'b0;
    case (cfg_state)
      CFG_CLAMP:    ld_clamp    = 1'b1;
      CFG_AREA:     ld_area     = 1'b1;
      CFG_VOLUME:   ld_volume   = 1'b1;
      CFG_POINTERS: ld_pointers = 1'b1;
      CFG_READY:    geom_ready  = 1'b1;
      default: ;
    endcase
  end

  // zero counts as one, anything above the limit as the limit
  always_comb begin
    if (size_x == '0) begin
      sx_clamped = X_W'(1);
    end else if (size_x > SIZE_XY_W'(X_LIM)) begin
      sx_clamped = X_W'(X_LIM);
    end else begin
      sx_clamped = X_W'(size_x);
    end
    if (size_y == '0) begin
      sy_clamped = Y_W'(1);
    end else if (size_y > SIZE_XY_W'(Y_LIM)) begin
      sy_clamped = Y_W'(Y_LIM);
    end else begin
      sy_clamped = Y_W'(size_y);
    end
    if (size_z == '0) begin
      sz_clamped = Z_W'(1);
    end else if (size_z > SIZE_Z_W'(MAX_Z)) begin
      sz_clamped = Z_W'(MAX_Z);
    end else begin
      sz_clamped = Z_W'(size_z);
    end
  end

  assign area_product   = sx * sy;
  assign volume_product = sxy * sz;
  assign sx_less1       = sx - X_W'(1);
  assign byp_psx        = (sy == Y_W'(1));
  assign byp_p1         = (sx == X_W'(1));

  always_ff @(posedge clk) begin
    if (ld_clamp) begin
      sx <= sx_clamped;
      sy <= sy_clamped;
      sz <= sz_clamped;
    end
    if (ld_area) begin
      sxy <= area_product[XY_W-1:0];
    end
    if (ld_volume) begin
      total <= volume_product[POS_W-1:0];
      d_psx <= sxy - XY_W'(sx);
    end
  end

  // ---------------- ring pointers ----------------
  logic [A1_W-1:0] wa1, ra1_psx, ra1_zm, d1_psx, d1_zm, ra1_psx_init, ra1_zm_init;
  logic [A2_W-1:0] wa2, ra2_p1, ra2_ym, d2_p1, d2_ym, ra2_p1_init, ra2_ym_init;

  assign d1_psx = A1_W'(d_psx);
  assign d1_zm  = A1_W'({sxy, 1'b0});
  assign d2_p1  = A2_W'(sx_less1);
  assign d2_ym  = A2_W'({sx, 1'b0});

  // place each read pointer its distance behind the write pointer, modulo ring depth
  assign ra1_psx_init = (wa1 >= d1_psx) ? wa1 - d1_psx : wa1 + A1_W'(DEPTH1) - d1_psx;
  assign ra1_zm_init  = (wa1 >= d1_zm)  ? wa1 - d1_zm  : wa1 + A1_W'(DEPTH1) - d1_zm;
  assign ra2_p1_init  = (wa2 >= d2_p1)  ? wa2 - d2_p1  : wa2 + A2_W'(DEPTH2) - d2_p1;
  assign ra2_ym_init  = (wa2 >= d2_ym)  ? wa2 - d2_ym  : wa2 + A2_W'(DEPTH2) - d2_ym;

  // ---------------- stage 0: accept ----------------
  logic adv, accept, push, emit0;
  logic in_full;
  logic [POS_W-1:0] in_pos, in_pos_inc;
  logic [X_W-1:0] ox;
  logic [Y_W-1:0] oy;
  logic [Z_W-1:0] oz;
  vsvm_tag_t tag0;
  logic s1_valid, s2_valid;
  logic res_valid, res_surface, res_last;

  assign adv          = !res_valid || results.ready;
  assign voxels.ready = adv && geom_ready;
  assign accept       = voxels.valid && voxels.ready;
  // a voxel beyond a full volume, or a drain before it is full, is dropped
  assign push         = accept && (voxels.drain ? in_full : !in_full);
  assign emit0        = voxels.drain || (in_pos >= POS_W'(sxy));
  assign in_pos_inc   = in_pos + POS_W'(1);

  always_comb begin
    tag0.emit = emit0;
    tag0.x_lo = (ox == '0);
    tag0.x_hi = (ox == sx_less1);
    tag0.y_lo = (oy == '0);
    tag0.y_hi = (oy == sy - Y_W'(1));
    tag0.z_lo = (oz == '0);
    tag0.z_hi = (oz == sz - Z_W'(1));
    tag0.last = tag0.x_hi && tag0.y_hi && tag0.z_hi;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      in_pos  <= '0;
      in_full <= 1'b0;
      ox      <= '0;
      oy      <= '0;
      oz      <= '0;
    end else if (push) begin
      if (tag0.emit && tag0.last) begin
        in_pos  <= '0;
        in_full <= 1'b0;
        ox      <= '0;
        oy      <= '0;
        oz      <= '0;
      end else begin
        if (!voxels.drain) begin
          in_pos  <= in_pos_inc;
          in_full <= (in_pos_inc == total);
        end
        if (tag0.emit) begin
          if (tag0.x_hi) begin
            ox <= '0;
            if (tag0.y_hi) begin
              oy <= '0;
              oz <= oz + Z_W'(1);
            end else begin
              oy <= oy + Y_W'(1);
            end
          end else begin
            ox <= ox + X_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wa1     <= '0;
      ra1_psx <= '0;
      ra1_zm  <= '0;
      wa2     <= '0;
      ra2_p1  <= '0;
      ra2_ym  <= '0;
    end else if (ld_pointers) begin
      ra1_psx <= ra1_psx_init;
      ra1_zm  <= ra1_zm_init;
      ra2_p1  <= ra2_p1_init;
      ra2_ym  <= ra2_ym_init;
    end else begin
      if (push) begin
        wa1     <= ring1_next(wa1);
        ra1_psx <= ring1_next(ra1_psx);
        ra1_zm  <= ring1_next(ra1_zm);
      end
      if (s1_valid && adv) begin
        wa2    <= ring2_next(wa2);
        ra2_p1 <= ring2_next(ra2_p1);
        ra2_ym <= ring2_next(ra2_ym);
      end
    end
  end

  // plane ring: every word in, read back one row below and two planes back
  logic [VALUE_BITS-1:0] ram1_psx, ram1_zm;

  vsvm_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH1)
  ) u_plane_ring (
    .clk     (clk),
    .we      (push),
    .waddr   (wa1),
    .wdata   (voxels.voxel_value[VALUE_BITS-1:0]),
    .re      (push),
    .raddr_a (ra1_psx),
    .raddr_b (ra1_zm),
    .rdata_a (ram1_psx),
    .rdata_b (ram1_zm)
  );

  // ---------------- stage 1 ----------------
  vsvm_tag_t s1_tag, s2_tag;
  logic [VALUE_BITS-1:0] s1_zp, v_psx;
  logic [VALUE_BITS-1:0] s2_zp, s2_zm, s2_psx;

  // single-row volume: the row-below word is the one just written
  assign v_psx = byp_psx ? s1_zp : ram1_psx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= push;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tag <= tag0;
      s1_zp  <= voxels.voxel_value[VALUE_BITS-1:0];
      s2_tag <= s1_tag;
      s2_zp  <= s1_zp;
      s2_zm  <= ram1_zm;
      s2_psx <= v_psx;
    end
  end

  // row ring: the row-below stream, read back as the next voxel and one row back
  logic [VALUE_BITS-1:0] ram2_p1, ram2_ym;

  vsvm_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH2)
  ) u_row_ring (
    .clk     (clk),
    .we      (s1_valid && adv),
    .waddr   (wa2),
    .wdata   (v_psx),
    .re      (s1_valid && adv),
    .raddr_a (ra2_p1),
    .raddr_b (ra2_ym),
    .rdata_a (ram2_p1),
    .rdata_b (ram2_ym)
  );

  // ---------------- stage 2: window and test ----------------
  logic [VALUE_BITS-1:0] v_p1, w_c, w_m;
  logic [VALUE_BITS-1:0] n_xm, n_xp, n_ym, n_yp, n_zm, n_zp;
  logic surf;

  assign v_p1 = byp_p1 ? s2_psx : ram2_p1;

  always_ff @(posedge clk) begin
    if (s2_valid && adv) begin
      w_m <= w_c;
      w_c <= v_p1;
    end
  end

  // a neighbour outside the volume takes the center value
  always_comb begin
    n_xm = s2_tag.x_lo ? w_c : w_m;
    n_xp = s2_tag.x_hi ? w_c : v_p1;
    n_ym = s2_tag.y_lo ? w_c : ram2_ym;
    n_yp = s2_tag.y_hi ? w_c : s2_psx;
    n_zm = s2_tag.z_lo ? w_c : s2_zm;
    n_zp = s2_tag.z_hi ? w_c : s2_zp;
    surf = (w_c != '0) && ((n_xm != n_xp) || (n_ym != n_yp) || (n_zm != n_zp));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= s2_valid && s2_tag.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_surface <= surf;
      res_last    <= s2_tag.last;
    end
  end

  assign results.valid        = res_valid;
  assign results.surface_flag = res_surface;
  assign results.last_voxel   = res_last;

  // ---------------- assertions ----------------
  a_full_at_total: assert property (@(posedge clk) disable iff (rst)
    in_full |-> (in_pos == total))
    else $error("input marked full away from volume size");

  a_coord_range: assert property (@(posedge clk) disable iff (rst)
    geom_ready |-> (ox < sx) && (oy < sy) && (oz < sz))
    else $error("output coordinate outside volume");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (push && tag0.emit && tag0.last) |=> (in_pos == '0) && !in_full && (ox == '0))
    else $error("positions not cleared after final voxel");

endmodule
